[rtl/lorenz_euler_step_core_defines.svh]
// Assertion macros shared by the checker.
`ifndef LORENZ_EULER_STEP_CORE_DEFINES_SVH
`define LORENZ_EULER_STEP_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent sequence starts in the cycle after the antecedent.
`define LES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

[rtl/les_pkg.sv]
`timescale 1ns / 1ps

package les_pkg;

   // Q8.24 format
   localparam int unsigned Q_W      = 32;
   localparam int unsigned FRAC_W   = 24;
   localparam int unsigned COEF_W   = 31;
   localparam int unsigned PROD_W   = 2 * Q_W;
   localparam int unsigned SAT_W    = PROD_W - FRAC_W;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [SAT_W-1:0] Q_MAX_W = 40'sd2147483647;
   localparam logic signed [SAT_W-1:0] Q_MIN_W = -40'sd2147483648;

   // Starting point (3, 15, 1)
   localparam logic signed [Q_W-1:0] INIT_X = 32'sd50331648;
   localparam logic signed [Q_W-1:0] INIT_Y = 32'sd251658240;
   localparam logic signed [Q_W-1:0] INIT_Z = 32'sd16777216;

   // Coefficient reset values
   localparam logic [COEF_W-1:0] RHO_RESET       = 31'd469762048;
   localparam logic [COEF_W-1:0] SIGMA_RESET     = 31'd167772160;
   localparam logic [COEF_W-1:0] BETA_RESET      = 31'd44744835;
   localparam logic [COEF_W-1:0] TIME_STEP_RESET = 31'd335544;

   typedef enum logic [1:0] {
      REG_RHO,
      REG_SIGMA,
      REG_BETA,
      REG_TIME_STEP
   } csr_index_type;

   // Sequencer: each working state does a multiply, a quantise or an add, some two at once
   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL_K,
      S_Q_K,
      S_MUL_T1,
      S_Q_T1,
      S_ADD_X,
      S_MUL_P,
      S_Q_P,
      S_SUB_PY,
      S_MUL_T2,
      S_Q_T2,
      S_ADD_Y,
      S_MUL_XY,
      S_Q_XY,
      S_Q_BZ,
      S_SUB_PQ,
      S_MUL_T3,
      S_Q_T3,
      S_ADD_Z,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [Q_W-1:0] val;
      logic                  ovf;
   } sat_result_type;

   // Clip to the signed Q8.24 range and flag a clip
   function automatic sat_result_type sat_q(input logic signed [SAT_W-1:0] v);
      sat_result_type r;
      r.val = v[Q_W-1:0];
      r.ovf = 1'b0;
      if (v > Q_MAX_W) begin
         r.val = Q_MAX;
         r.ovf = 1'b1;
      end else if (v < Q_MIN_W) begin
         r.val = Q_MIN;
         r.ovf = 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/lorenz_euler_step_core.sv]
`timescale 1ns / 1ps
// Step beat: after acceptance the sequencer walks S_MUL_K to S_ADD_Z, sharing the
//   single 32x32 multiplier and adder, then S_OUT registers the result once the
//   output is free and returns to idle. Restart beat: straight to S_OUT.
// One beat in flight at a time; a waiting result does not block the next request.
// Synchronous active-high reset: point back to (3, 15, 1), coefficients to
//   28, 10, 2.667, 0.02, both channels idle.
module lorenz_euler_step_core (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [les_pkg::Q_W-1:0]   rsp_x_out,
   output logic signed [les_pkg::Q_W-1:0]   rsp_y_out,
   output logic signed [les_pkg::Q_W-1:0]   rsp_z_out,
   output logic                             rsp_saturated,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [les_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [les_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [les_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import les_pkg::*;

   state_type state_ff, state_in;

   logic [COEF_W-1:0] rho_ff, sigma_ff, beta_ff, time_step_ff;

   logic signed [Q_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [Q_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic signed [Q_W-1:0] d_ff, k_ff, t_ff, p_ff, d_in, k_in, t_in, p_in;
   logic signed [Q_W-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic                  sat_ff, sat_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic signed [Q_W-1:0] mul_a, mul_b, add_a, add_b;
   logic                  add_sub;
   logic signed [Q_W+1:0] add_a_ext, add_b_ext, add_sum;
   sat_result_type        add_res, q_res;
   logic signed [Q_W-1:0] rho_s, sigma_s, beta_s, dt_s;
   csr_index_type         csr_idx;
   logic                  csr_wr;

   // Register port
   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      unique case (csr_idx)
         REG_RHO:       prdata = {1'b0, rho_ff};
         REG_SIGMA:     prdata = {1'b0, sigma_ff};
         REG_BETA:      prdata = {1'b0, beta_ff};
         REG_TIME_STEP: prdata = {1'b0, time_step_ff};
         default:       prdata = '0;
      endcase
   end

   // Coefficients as signed operands
   assign rho_s   = $signed({1'b0, rho_ff});
   assign sigma_s = $signed({1'b0, sigma_ff});
   assign beta_s  = $signed({1'b0, beta_ff});
   assign dt_s    = $signed({1'b0, time_step_ff});

   // Operand selection for the shared multiplier and adder
   always_comb begin
      mul_a   = pos_x_ff;
      mul_b   = pos_y_ff;
      add_a   = pos_y_ff;
      add_b   = pos_x_ff;
      add_sub = 1'b1;
      unique case (state_ff)
         S_MUL_K: begin
            mul_a = dt_s;
            mul_b = sigma_s;
         end
         S_MUL_T1: begin
            mul_a = k_ff;
            mul_b = d_ff;
         end
         S_Q_T1: begin
            add_a = rho_s;
            add_b = pos_z_ff;
         end
         S_ADD_X: begin
            add_a   = pos_x_ff;
            add_b   = t_ff;
            add_sub = 1'b0;
         end
         S_MUL_P: begin
            mul_b = d_ff;
         end
         S_SUB_PY: begin
            add_a = p_ff;
            add_b = pos_y_ff;
         end
         S_MUL_T2, S_MUL_T3: begin
            mul_a = dt_s;
            mul_b = d_ff;
         end
         S_ADD_Y: begin
            add_a   = pos_y_ff;
            add_b   = t_ff;
            add_sub = 1'b0;
         end
         S_Q_XY: begin
            // issue beta*z while x*y is quantised
            mul_a = beta_s;
            mul_b = pos_z_ff;
         end
         S_SUB_PQ: begin
            add_a = p_ff;
            add_b = k_ff;
         end
         S_ADD_Z: begin
            add_a   = pos_z_ff;
            add_b   = t_ff;
            add_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Shared multiplier, product registered
   assign prod_in = mul_a * mul_b;

   // Shared adder with saturation
   assign add_a_ext = (Q_W + 2)'(add_a);
   assign add_b_ext = (Q_W + 2)'(add_b);
   assign add_sum   = add_sub ? (add_a_ext - add_b_ext) : (add_a_ext + add_b_ext);
   assign add_res   = sat_q(SAT_W'(add_sum));

   // Floor quantise of the product: drop the fraction bits
   assign q_res = sat_q($signed(prod_ff[PROD_W-1:FRAC_W]));

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sat_in = 1'b0;
               if (req_restart) begin
                  nx_in    = INIT_X;
                  ny_in    = INIT_Y;
                  nz_in    = INIT_Z;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL_K;
               end
            end
         end
         S_MUL_K: begin
            d_in     = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_Q_K;
         end
         S_Q_K: begin
            k_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_MUL_T1;
         end
         S_MUL_T1: state_in = S_Q_T1;
         S_Q_T1: begin
            t_in     = q_res.val;
            d_in     = add_res.val;
            sat_in   = sat_ff | q_res.ovf | add_res.ovf;
            state_in = S_ADD_X;
         end
         S_ADD_X: begin
            nx_in    = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_MUL_P;
         end
         S_MUL_P: state_in = S_Q_P;
         S_Q_P: begin
            p_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_SUB_PY;
         end
         S_SUB_PY: begin
            d_in     = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_MUL_T2;
         end
         S_MUL_T2: state_in = S_Q_T2;
         S_Q_T2: begin
            t_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_ADD_Y;
         end
         S_ADD_Y: begin
            ny_in    = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_MUL_XY;
         end
         S_MUL_XY: state_in = S_Q_XY;
         S_Q_XY: begin
            p_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_Q_BZ;
         end
         S_Q_BZ: begin
            k_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_SUB_PQ;
         end
         S_SUB_PQ: begin
            d_in     = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_MUL_T3;
         end
         S_MUL_T3: state_in = S_Q_T3;
         S_Q_T3: begin
            t_in     = q_res.val;
            sat_in   = sat_ff | q_res.ovf;
            state_in = S_ADD_Z;
         end
         S_ADD_Z: begin
            nz_in    = add_res.val;
            sat_in   = sat_ff | add_res.ovf;
            state_in = S_OUT;
         end
         S_OUT: begin
            // commit the point once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               pos_x_in     = nx_ff;
               pos_y_in     = ny_ff;
               pos_z_in     = nz_ff;
               rsp_x_in     = nx_ff;
               rsp_y_in     = ny_ff;
               rsp_z_in     = nz_ff;
               rsp_sat_in   = sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Architectural state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff       <= RHO_RESET;
         sigma_ff     <= SIGMA_RESET;
         beta_ff      <= BETA_RESET;
         time_step_ff <= TIME_STEP_RESET;
         pos_x_ff     <= INIT_X;
         pos_y_ff     <= INIT_Y;
         pos_z_ff     <= INIT_Z;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_idx)
               REG_RHO:       rho_ff       <= pwdata[COEF_W-1:0];
               REG_SIGMA:     sigma_ff     <= pwdata[COEF_W-1:0];
               REG_BETA:      beta_ff      <= pwdata[COEF_W-1:0];
               REG_TIME_STEP: time_step_ff <= pwdata[COEF_W-1:0];
               default: begin
               end
            endcase
         end
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers, no reset
   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      d_ff       <= d_in;
      k_ff       <= k_in;
      t_ff       <= t_in;
      p_ff       <= p_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      nz_ff      <= nz_in;
      sat_ff     <= sat_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_out     = rsp_x_ff;
   assign rsp_y_out     = rsp_y_ff;
   assign rsp_z_out     = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

[rtl/les_checker.sv]
`timescale 1ns / 1ps
`include "lorenz_euler_step_core_defines.svh"

module les_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_restart,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [les_pkg::Q_W-1:0] rsp_x_out,
   input logic signed [les_pkg::Q_W-1:0] rsp_y_out,
   input logic signed [les_pkg::Q_W-1:0] rsp_z_out,
   input logic                           rsp_saturated
);
   import les_pkg::*;

   // one beat in flight: busy straight after a request
   `LES_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, (!req_ready), "ready after accept")

   // a new result only follows a busy cycle
   `LES_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "result from nowhere")

   // restart with a free output passes through S_OUT and reports the start point
   `LES_ASSERT_NEXT(a_restart_point,
      req_valid && req_ready && req_restart && (!rsp_valid || rsp_ready),
      ##1 (rsp_valid && rsp_x_out == INIT_X && rsp_y_out == INIT_Y &&
           rsp_z_out == INIT_Z && !rsp_saturated),
      "restart point wrong")

   // stalled result beat holds
   `LES_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      (rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out) && $stable(rsp_z_out) &&
       $stable(rsp_saturated)),
      "stalled result changed")

endmodule

bind lorenz_euler_step_core les_checker u_les_checker (.*);

[bench/lorenz_euler_step_core_test.sv]
`timescale 1ns / 1ps

module lorenz_euler_step_core_test;
   import les_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int MISMATCH_LOG = 10;
   localparam int unsigned Q_ONE = 32'd16777216;

   typedef struct packed {
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
      logic                  sat;
   } lorenz_point_type;

   typedef enum {
      CFG_DEFAULT,
      CFG_PHYSICAL,
      CFG_WIDE,
      CFG_EXTREME
   } coef_mix_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [Q_W-1:0] rsp_x_out;
   logic signed [Q_W-1:0] rsp_y_out;
   logic signed [Q_W-1:0] rsp_z_out;
   logic                  rsp_saturated;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow of the block: coefficients and the point held
   logic [COEF_W-1:0]     coef [4] = '{RHO_RESET, SIGMA_RESET, BETA_RESET, TIME_STEP_RESET};
   logic signed [Q_W-1:0] pos_x = INIT_X;
   logic signed [Q_W-1:0] pos_y = INIT_Y;
   logic signed [Q_W-1:0] pos_z = INIT_Z;
   logic                  step_clipped;

   lorenz_point_type expected_points [$];
   int fail_count     = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   lorenz_euler_step_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_x_out    (rsp_x_out),
      .rsp_y_out    (rsp_y_out),
      .rsp_z_out    (rsp_z_out),
      .rsp_saturated(rsp_saturated),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Q8.24 clip, noting any clip in this step
   function automatic logic signed [Q_W-1:0] q_clip(input longint v);
      if (v > 64'sd2147483647) begin
         step_clipped = 1'b1;
         return Q_MAX;
      end
      if (v < -64'sd2147483648) begin
         step_clipped = 1'b1;
         return Q_MIN;
      end
      return v[Q_W-1:0];
   endfunction

   // Q8.24 product; arithmetic shift rounds toward minus infinity
   function automatic logic signed [Q_W-1:0] q_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return q_clip(p >>> FRAC_W);
   endfunction

   // Next point for one tick, updating the shadow point
   function automatic lorenz_point_type lorenz_advance(input bit restart);
      lorenz_point_type r;
      longint x, y, z, dt;
      logic signed [Q_W-1:0] d, k, t, p, bz;
      logic signed [Q_W-1:0] nx, ny, nz;
      step_clipped = 1'b0;
      if (restart) begin
         pos_x = INIT_X;
         pos_y = INIT_Y;
         pos_z = INIT_Z;
      end else begin
         x  = pos_x;
         y  = pos_y;
         z  = pos_z;
         dt = longint'(coef[REG_TIME_STEP]);
         // x' = x + (dt*sigma)*(y - x)
         d  = q_clip(y - x);
         k  = q_mul(dt, longint'(coef[REG_SIGMA]));
         t  = q_mul(longint'(k), longint'(d));
         nx = q_clip(x + longint'(t));
         // y' = y + dt*(x*(rho - z) - y)
         d  = q_clip(longint'(coef[REG_RHO]) - z);
         p  = q_mul(x, longint'(d));
         d  = q_clip(longint'(p) - y);
         t  = q_mul(dt, longint'(d));
         ny = q_clip(y + longint'(t));
         // z' = z + dt*(x*y - beta*z)
         p  = q_mul(x, y);
         bz = q_mul(longint'(coef[REG_BETA]), z);
         d  = q_clip(longint'(p) - longint'(bz));
         t  = q_mul(dt, longint'(d));
         nz = q_clip(z + longint'(t));
         pos_x = nx;
         pos_y = ny;
         pos_z = nz;
      end
      r.x   = pos_x;
      r.y   = pos_y;
      r.z   = pos_z;
      r.sat = step_clipped;
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MISMATCH_LOG)
            $display("mismatch %s: expected %h, got %h", what, want, got);
      end
   endtask

   // Result beats against the oldest expected point
   always @(posedge clock) begin : result_check
      lorenz_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            fail_count++;
            if (fail_count <= MISMATCH_LOG)
               $display("unexpected result beat: x %h y %h z %h sat %b",
                        rsp_x_out, rsp_y_out, rsp_z_out, rsp_saturated);
         end else begin
            want = expected_points.pop_front();
            check_field("x_out", want.x, rsp_x_out);
            check_field("y_out", want.y, rsp_y_out);
            check_field("z_out", want.z, rsp_z_out);
            check_field("saturated", 32'(want.sat), 32'(rsp_saturated));
         end
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // One tick on the request channel; valid is left high for a following beat
   task automatic send_tick(input bit restart);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_points.push_back(lorenz_advance(restart));
   endtask

   // Sender holds off until every expected point has arrived
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      coef[idx] = value[COEF_W-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input csr_index_type idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      check_field("register readback", 32'(coef[idx]), {1'b0, prdata[COEF_W-1:0]});
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain, then write and read back all four coefficients
   task automatic program_values(input logic [31:0] rho, input logic [31:0] sigma,
                                 input logic [31:0] beta, input logic [31:0] dt);
      wait_all_results();
      csr_write(REG_RHO, rho);
      csr_write(REG_SIGMA, sigma);
      csr_write(REG_BETA, beta);
      csr_write(REG_TIME_STEP, dt);
      csr_read(REG_RHO);
      csr_read(REG_SIGMA);
      csr_read(REG_BETA);
      csr_read(REG_TIME_STEP);
   endtask

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic program_coefs(input coef_mix_type mix);
      case (mix)
         CFG_DEFAULT: begin
            program_values(RHO_RESET, SIGMA_RESET, BETA_RESET, TIME_STEP_RESET);
         end
         CFG_PHYSICAL: begin
            program_values($urandom_range(0, 60 * Q_ONE), $urandom_range(0, 20 * Q_ONE),
                           $urandom_range(0, 8 * Q_ONE), $urandom_range(16777, 838860));
         end
         CFG_WIDE: begin
            program_values($urandom, $urandom, $urandom, $urandom);
         end
         default: begin
            program_values(extreme_word(), extreme_word(), extreme_word(), extreme_word());
         end
      endcase
   endtask

   task automatic test_reset_registers();
      csr_read(REG_RHO);
      csr_read(REG_SIGMA);
      csr_read(REG_BETA);
      csr_read(REG_TIME_STEP);
   endtask

   task automatic test_restart_and_step();
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Coefficient extremes: saturation, zero step, masked top bit
   task automatic test_register_extremes();
      program_values(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      program_values(32'h0, 32'h0, 32'h0, 32'h0);
      repeat (2) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      program_values(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, Q_ONE);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      program_values(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
      repeat (2) send_tick(1'b0);
      program_values(RHO_RESET, SIGMA_RESET, BETA_RESET, TIME_STEP_RESET);
      send_tick(1'b1);
   endtask

   // Runs of steps from a fresh or carried-over point under varied coefficients
   task automatic test_trajectories(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            program_coefs(CFG_DEFAULT);
         else if (pick < 7)
            program_coefs(CFG_PHYSICAL);
         else if (pick < 9)
            program_coefs(CFG_WIDE);
         else
            program_coefs(CFG_EXTREME);
         if ($urandom_range(0, 3) != 0) begin
            send_tick(1'b1);
            sent++;
         end
         repeat ($urandom_range(10, 60)) begin
            send_tick($urandom_range(0, 99) < 4);
            sent++;
            if ($urandom_range(0, 199) == 0)
               wait_all_results();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_registers();
      test_restart_and_step();
      test_register_extremes();

      send_idle_pct = 32;
      recv_idle_pct = 88;
      test_trajectories(517);
      send_idle_pct = 88;
      recv_idle_pct = 32;
      test_trajectories(517);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_trajectories(516);

      wait_all_results();
      repeat (40) @(posedge clock);
      fail_count += expected_points.size();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
